// ===== rtl/l2n_pkg.sv =====
`timescale 1ns / 1ps

package l2n_pkg;

  localparam int ELEM_W           = 16;   // Q3.12 element / Q0.15 result
  localparam int CFG_W            = 32;   // min_sum_squares
  localparam int SUM_W            = 38;   // sum of squares, Q.24
  localparam int SQ_W             = 32;   // one square
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int MAX_ELEMENTS_LIM = 64;

  // digit-by-digit root: two bits of the operand per iteration
  localparam int SQRT_ITERS = SUM_W / 2;
  localparam int ROOT_W     = SQRT_ITERS;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int ITER_W     = $clog2(SQRT_ITERS);

  // restoring divide, element magnitude below the norm -> 15 quotient bits
  localparam int Q_W        = ELEM_W - 1;
  localparam int DIV_BITS   = 5;
  localparam int DIV_CYCLES = Q_W / DIV_BITS;
  localparam int DV_W       = ROOT_W + 1;
  localparam int DCNT_W     = $clog2(DIV_CYCLES + 1);

  localparam logic [Q_W-1:0] Q15_MAX = {Q_W{1'b1}};

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_CHECK = 6'b000010,
    S_ROOT  = 6'b000100,
    S_READ  = 6'b001000,
    S_DIV   = 6'b010000,
    S_PUT   = 6'b100000
  } state_t;

endpackage

// ===== rtl/l2n_if.sv =====
`timescale 1ns / 1ps

interface l2n_elem_if;
  logic                              valid;
  logic                              ready;
  logic signed [l2n_pkg::ELEM_W-1:0] element_value;
  logic                              is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface l2n_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [l2n_pkg::ELEM_W-1:0] result_value;
  logic                              was_scaled;
  logic                              was_truncated;
  logic                              is_final;

  modport source (output valid, output result_value, output was_scaled,
                  output was_truncated, output is_final, input ready);
  modport sink   (input valid, input result_value, input was_scaled,
                  input was_truncated, input is_final, output ready);
endinterface

interface l2n_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [l2n_pkg::CFG_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/l2_vector_normalize.sv =====
`timescale 1ns / 1ps

// channel   dir  payload                                              request when
// element   in   element_value[15:0] s, is_last                       valid & ready
// result    out  result_value[15:0] s, was_scaled, was_truncated,     valid & ready
//                is_final
// cfg       in   data[31:0] -> min_sum_squares                        valid & ready
//
// Loading takes one element a cycle. After the last element: a check state, then
// 19 root iterations (one pair of sum bits a cycle) when the vector is scaled.
// Each result then passes through store read, operand latch, divide steps
// (5 quotient bits each) and output load. A stalled result register holds the
// emit sequence. Element store is not cleared on reset; reset is synchronous.

module l2_vector_normalize #(
  parameter int MAX_ELEMENTS = l2n_pkg::MAX_ELEMENTS_DEF
) (
  input logic           clk,
  input logic           rst,
  l2n_elem_if.sink      element,
  l2n_result_if.source  result,
  l2n_cfg_if.sink       cfg
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  l2n_pkg::state_t state;

  logic [CW-1:0]                   count;
  logic [CW-1:0]                   idx;
  logic [l2n_pkg::SUM_W-1:0]       sum;
  logic                            ovf;
  logic [l2n_pkg::CFG_W-1:0]       min_sum;
  logic [l2n_pkg::ITER_W-1:0]      iter;
  logic [l2n_pkg::DCNT_W-1:0]      dcnt;
  logic                            out_valid;

  logic signed [l2n_pkg::ELEM_W-1:0] store [MAX_ELEMENTS];
  logic [l2n_pkg::ELEM_W-1:0]        rd_data;

  // datapath
  logic                            scale;
  logic [l2n_pkg::SUM_W-1:0]       sq_x;
  logic [l2n_pkg::SQ_REM_W-1:0]    sq_rem;
  logic [l2n_pkg::ROOT_W-1:0]      sq_root;
  logic [l2n_pkg::ELEM_W-1:0]      raw;
  logic                            neg;
  logic                            sat;
  logic [l2n_pkg::DV_W-1:0]        dv_rem;
  logic [l2n_pkg::Q_W-1:0]         dv_q;

  logic signed [l2n_pkg::ELEM_W-1:0] out_value;
  logic                              out_scaled;
  logic                              out_trunc;
  logic                              out_final;

  logic                            elem_acc;
  logic                            wr_en;
  logic                            put_go;
  logic                            is_final_elem;
  logic                            sum_above;
  logic signed [l2n_pkg::SQ_W-1:0] square;
  logic [l2n_pkg::ELEM_W-1:0]      mag;
  logic [l2n_pkg::SQ_REM_W-1:0]    sq_rem_sh;
  logic [l2n_pkg::SQ_REM_W-1:0]    sq_trial;
  logic                            sq_ge;
  logic [l2n_pkg::SQ_REM_W-1:0]    sq_rem_next;
  logic [l2n_pkg::ROOT_W-1:0]      sq_root_next;
  logic [l2n_pkg::DV_W-1:0]        dv_rem_next;
  logic [l2n_pkg::Q_W-1:0]         dv_q_next;
  logic [l2n_pkg::Q_W-1:0]         q_mag;
  logic [l2n_pkg::ELEM_W-1:0]      q_pos;
  logic [l2n_pkg::ELEM_W-1:0]      res_next;

  assign element.ready = (state == l2n_pkg::S_LOAD);
  assign cfg.ready     = 1'b1;

  assign elem_acc  = element.valid && element.ready;
  assign wr_en     = elem_acc && (count < CW'(MAX_ELEMENTS));
  assign square    = element.element_value * element.element_value;
  assign sum_above = sum > {{(l2n_pkg::SUM_W - l2n_pkg::CFG_W){1'b0}}, min_sum};

  assign put_go        = (state == l2n_pkg::S_PUT) && (!out_valid || result.ready);
  assign is_final_elem = (CW'(idx + CW'(1)) == count);

  // root iteration
  assign sq_rem_sh    = {sq_rem[l2n_pkg::SQ_REM_W-3:0], sq_x[l2n_pkg::SUM_W-1 -: 2]};
  assign sq_trial     = {1'b0, sq_root, 2'b01};
  assign sq_ge        = sq_rem_sh >= sq_trial;
  assign sq_rem_next  = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
  assign sq_root_next = {sq_root[l2n_pkg::ROOT_W-2:0], sq_ge};

  assign mag = rd_data[l2n_pkg::ELEM_W-1] ? (~rd_data + l2n_pkg::ELEM_W'(1)) : rd_data;

  always_comb begin
    logic [l2n_pkg::DV_W-1:0] dv_t;
    dv_rem_next = dv_rem;
    dv_q_next   = dv_q;
    for (int k = 0; k < l2n_pkg::DIV_BITS; k++) begin
      dv_t = {dv_rem_next[l2n_pkg::DV_W-2:0], 1'b0};
      if (dv_t >= {1'b0, sq_root}) begin
        dv_rem_next = dv_t - {1'b0, sq_root};
        dv_q_next   = {dv_q_next[l2n_pkg::Q_W-2:0], 1'b1};
      end else begin
        dv_rem_next = dv_t;
        dv_q_next   = {dv_q_next[l2n_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  // magnitude >= norm means the quotient is at least 1.0
  assign q_mag    = sat ? l2n_pkg::Q15_MAX : dv_q;
  assign q_pos    = {1'b0, q_mag};
  assign res_next = !scale ? raw : (neg ? (~q_pos + l2n_pkg::ELEM_W'(1)) : q_pos);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[count[AW-1:0]] <= element.element_value;
    end
    rd_data <= store[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= l2n_pkg::S_LOAD;
      count     <= '0;
      idx       <= '0;
      sum       <= '0;
      ovf       <= 1'b0;
      min_sum   <= '0;
      iter      <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        min_sum <= cfg.data;
      end
      if (put_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        l2n_pkg::S_LOAD: begin
          if (elem_acc) begin
            if (wr_en) begin
              sum   <= sum + {{(l2n_pkg::SUM_W - l2n_pkg::SQ_W){1'b0}}, square};
              count <= CW'(count + CW'(1));
            end else begin
              ovf <= 1'b1;
            end
            if (element.is_last) begin
              state <= l2n_pkg::S_CHECK;
            end
          end
        end
        l2n_pkg::S_CHECK: begin
          idx   <= '0;
          iter  <= '0;
          state <= sum_above ? l2n_pkg::S_ROOT : l2n_pkg::S_READ;
        end
        l2n_pkg::S_ROOT: begin
          iter <= l2n_pkg::ITER_W'(iter + l2n_pkg::ITER_W'(1));
          if (iter == l2n_pkg::ITER_W'(l2n_pkg::SQRT_ITERS - 1)) begin
            state <= l2n_pkg::S_READ;
          end
        end
        l2n_pkg::S_READ: begin
          dcnt  <= '0;
          state <= l2n_pkg::S_DIV;
        end
        l2n_pkg::S_DIV: begin
          dcnt <= l2n_pkg::DCNT_W'(dcnt + l2n_pkg::DCNT_W'(1));
          if (dcnt == l2n_pkg::DCNT_W'(l2n_pkg::DIV_CYCLES)) begin
            state <= l2n_pkg::S_PUT;
          end
        end
        l2n_pkg::S_PUT: begin
          if (put_go) begin
            idx <= CW'(idx + CW'(1));
            if (is_final_elem) begin
              count <= '0;
              sum   <= '0;
              ovf   <= 1'b0;
              state <= l2n_pkg::S_LOAD;
            end else begin
              state <= l2n_pkg::S_READ;
            end
          end
        end
        default: state <= l2n_pkg::S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == l2n_pkg::S_CHECK) begin
      scale   <= sum_above;
      sq_x    <= sum;
      sq_rem  <= '0;
      sq_root <= '0;
    end
    if (state == l2n_pkg::S_ROOT) begin
      sq_x    <= {sq_x[l2n_pkg::SUM_W-3:0], 2'b00};
      sq_rem  <= sq_rem_next;
      sq_root <= sq_root_next;
    end
    if (state == l2n_pkg::S_DIV) begin
      if (dcnt == '0) begin
        raw    <= rd_data;
        neg    <= rd_data[l2n_pkg::ELEM_W-1];
        sat    <= {{(l2n_pkg::ROOT_W - l2n_pkg::ELEM_W){1'b0}}, mag} >= sq_root;
        dv_rem <= {{(l2n_pkg::DV_W - l2n_pkg::ELEM_W){1'b0}}, mag};
        dv_q   <= '0;
      end else begin
        dv_rem <= dv_rem_next;
        dv_q   <= dv_q_next;
      end
    end
    if (put_go) begin
      out_value  <= res_next;
      out_scaled <= scale;
      out_trunc  <= ovf;
      out_final  <= is_final_elem;
    end
  end

  assign result.valid         = out_valid;
  assign result.result_value  = out_value;
  assign result.was_scaled    = out_scaled;
  assign result.was_truncated = out_trunc;
  assign result.is_final      = out_final;

endmodule

// ===== rtl/l2n_checker.sv =====
`timescale 1ns / 1ps

module l2n_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [l2n_pkg::ELEM_W-1:0] out_value,
  input logic                              out_scaled
);

  // a closing element starts the emit phase, so no further request is taken
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("element taken right after a closing element");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // saturation is symmetric: a scaled result never reaches -1.0
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_scaled |-> out_value != 16'sh8000)
    else $error("scaled result at -32768");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled result changed");

endmodule

bind l2_vector_normalize l2n_checker u_l2n_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (element.valid),
  .in_ready   (element.ready),
  .in_last    (element.is_last),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_value  (result.result_value),
  .out_scaled (result.was_scaled)
);

// ===== bench/l2_vector_normalize_test.sv =====
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [15:0] value;
  logic               scaled;
  logic               truncated;
  logic               closes_vector;
} norm_result_t;

class norm_scoreboard;
  localparam int DEPTH = l2n_pkg::MAX_ELEMENTS_DEF;

  logic [15:0]  stored [DEPTH];
  logic [37:0]  square_sum;
  int unsigned  count;
  bit           overflowed;
  logic [31:0]  min_sum;
  norm_result_t awaited[$];
  int           errors;

  function new();
    square_sum = '0;
    count      = 0;
    overflowed = 1'b0;
    min_sum    = '0;
    errors     = 0;
  endfunction

  function void set_min_sum(logic [31:0] v);
    min_sum = v;
  endfunction

  function logic [18:0] floor_root(logic [37:0] x);
    logic [18:0]     r;
    logic [18:0]     t;
    longint unsigned tt;
    r = '0;
    for (int b = 18; b >= 0; b--) begin
      t  = r | (19'd1 << b);
      tt = t;
      if (tt * tt <= x) r = t;
    end
    return r;
  endfunction

  // Q3.12 over Q.12 norm gives Q0.15; truncate, then clamp to +/-32767
  function logic [15:0] scale_to_q15(logic signed [15:0] v, logic [18:0] norm);
    longint          sv;
    longint unsigned mag;
    longint unsigned q;
    sv  = v;
    mag = (sv < 0) ? -sv : sv;
    q   = (mag << 15) / norm;
    if (q > 32767) q = 32767;
    return (sv < 0) ? 16'(0 - q) : 16'(q);
  endfunction

  function void note_element(logic signed [15:0] v, bit last);
    longint       sq;
    bit           scale;
    logic [18:0]  norm;
    norm_result_t r;
    if (count < DEPTH) begin
      stored[count] = v;
      sq = longint'(v) * longint'(v);
      square_sum += 38'(sq);
      count++;
    end else begin
      overflowed = 1'b1;
    end
    if (!last) return;
    scale = square_sum > {6'd0, min_sum};
    norm  = scale ? floor_root(square_sum) : '0;
    if (norm == 0) scale = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      r.value         = scale ? scale_to_q15(stored[i], norm) : stored[i];
      r.scaled        = scale;
      r.truncated     = overflowed;
      r.closes_vector = (i + 1 == count);
      awaited.push_back(r);
    end
    square_sum = '0;
    count      = 0;
    overflowed = 1'b0;
  endfunction

  function void check_result(norm_result_t got);
    norm_result_t exp;
    if (awaited.size() == 0) begin
      $error("unexpected result: value %0d scaled %0b truncated %0b final %0b",
             got.value, got.scaled, got.truncated, got.closes_vector);
      errors++;
      return;
    end
    exp = awaited.pop_front();
    if (got.value !== exp.value) begin
      $error("result_value: expected %0d, got %0d", exp.value, got.value);
      errors++;
    end
    if (got.scaled !== exp.scaled) begin
      $error("was_scaled: expected %0b, got %0b", exp.scaled, got.scaled);
      errors++;
    end
    if (got.truncated !== exp.truncated) begin
      $error("was_truncated: expected %0b, got %0b", exp.truncated, got.truncated);
      errors++;
    end
    if (got.closes_vector !== exp.closes_vector) begin
      $error("is_final: expected %0b, got %0b", exp.closes_vector, got.closes_vector);
      errors++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module l2_vector_normalize_test;

  localparam int DEPTH          = l2n_pkg::MAX_ELEMENTS_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  l2n_elem_if   element_ch ();
  l2n_result_if result_ch ();
  l2n_cfg_if    cfg_ch ();

  l2_vector_normalize #(
    .MAX_ELEMENTS(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .element (element_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  norm_scoreboard sb;
  bit             rush = 1'b0;
  int             stall_left = 0;
  int             quiet_cycles = 0;
  int             items_sent = 0;

  always #5 clk = ~clk;

  initial begin
    element_ch.valid         = 1'b0;
    element_ch.element_value = '0;
    element_ch.is_last       = 1'b0;
    result_ch.ready          = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.data              = '0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap(int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic signed [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom);
    if (r == 5) begin
      case ($urandom_range(0, 4))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return -16'sd1;
        3: return 16'sd1;
        default: return 16'sd0;
      endcase
    end
    if (r < 8) return 16'($signed($urandom_range(0, 128)) - 64);
    return 16'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if (!rush && $urandom_range(0, 99) < 20) stall_left <= idle_gap(0);
    end
  end

  always @(posedge clk) begin
    norm_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.value         = result_ch.result_value;
      got.scaled        = result_ch.was_scaled;
      got.truncated     = result_ch.was_truncated;
      got.closes_vector = result_ch.is_final;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (element_ch.valid && element_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("l2_vector_normalize_test: FAIL");
      $finish;
    end
  end

  task automatic send_element(logic signed [15:0] v, bit last);
    int gap;
    gap = rush ? 0 : idle_gap(50);
    repeat (gap) begin
      @(negedge clk);
      element_ch.valid <= 1'b0;
    end
    @(negedge clk);
    element_ch.valid         <= 1'b1;
    element_ch.element_value <= v;
    element_ch.is_last       <= last;
    do @(posedge clk); while (!element_ch.ready);
    sb.note_element(v, last);
    items_sent++;
  endtask

  task automatic send_random_vector(int len);
    for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
  endtask

  // hold the sender until every expected result is out, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    element_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_sum(logic [31:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_min_sum(v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] floors [6];
    int          phase_items;
    int          len;
    int          r;

    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    write_min_sum(32'd0);
    send_element(16'sd0, 1'b1);        // zero sum passes through
    send_element(16'sd1, 1'b1);        // quotient clamps to 32767
    send_element(-16'sd1, 1'b1);
    send_element(-16'sd32768, 1'b1);   // clamps to -32767, never -32768
    send_element(16'sd32767, 1'b0);
    send_element(-16'sd32768, 1'b0);
    send_element(16'sd0, 1'b1);
    repeat (3) send_element(16'sd4096, 1'b0);
    send_element(16'sd4096, 1'b1);
    wait_drained();
    write_min_sum(32'd1 << 24);
    send_element(16'sd4096, 1'b1);     // sum equal to floor: unscaled
    send_element(-16'sd4097, 1'b1);    // just above floor
    wait_drained();
    write_min_sum(32'hFFFF_FFFF);
    send_element(16'sd32767, 1'b0);
    send_element(-16'sd32768, 1'b0);
    send_element(16'sd1000, 1'b1);

    // random phases, one floor setting each
    floors[0] = 32'd0;
    floors[1] = $urandom_range(1 << 18, 1 << 26);
    floors[2] = 32'd1;
    floors[3] = 32'hFFFF_FFFF;
    floors[4] = $urandom;
    floors[5] = 32'd0;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      rush = (phase == 2);
      write_min_sum(floors[phase]);
      phase_items = 0;
      // overfull vector, then an exactly full one
      if (phase == 1) begin
        len = $urandom_range(DEPTH + 1, DEPTH + 3);
        send_random_vector(len);
        phase_items += len;
      end
      if (phase == 3) begin
        send_random_vector(DEPTH);
        phase_items += DEPTH;
      end
      while (phase_items < 4) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 4);
        else if (r < 95) len = $urandom_range(5, 12);
        else len = $urandom_range(13, 24);
        send_random_vector(len);
        phase_items += len;
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("l2_vector_normalize_test: PASS");
    end else begin
      $display("l2_vector_normalize_test: FAIL");
    end
    $finish;
  end

endmodule
